FILE: hw/rtl/tcw_pkg.sv
// Package for the text console writer: screen geometry, cell codes and the
// cursor command and status types. No dependencies.
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;

    localparam int CURSOR_W = 11;
    localparam int ADDR_W   = $clog2(NCELLS);
    localparam int ROW_W    = $clog2(ROWS + 1);
    localparam int COL_W    = $clog2(COLS);
    localparam int CELL_W   = 16;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [3:0] BLANK_FG     = 4'h0;
    localparam logic [3:0] BLANK_BG     = 4'hF;

    localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_FG, BLANK_BG, CH_SPACE};

    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_CLEAR,
        CUR_SCROLL,
        CUR_NEWLINE,
        CUR_BACK,
        CUR_ADVANCE
    } cur_cmd_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [ROW_W-1:0]    row;
    } cur_status_t;

endpackage

FILE: hw/rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/tcw_cursor.sv
// Cursor unit: holds the cursor, the cursor row and the cursor's own row and
// column, and applies one command per cycle. Depends on tcw_pkg.
module tcw_cursor
    import tcw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cur_cmd_t    cmd,
    output cur_status_t status
);

    localparam logic [CURSOR_W-1:0] SCROLL_CURSOR = CURSOR_W'((ROWS - 1) * COLS);
    localparam logic [ROW_W-1:0]    LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]    LAST_COL      = COL_W'(COLS - 1);

    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    // crow/ccol track cursor / COLS and cursor % COLS, so no divider is needed.
    logic [ROW_W-1:0]    crow_reg, crow_next;
    logic [COL_W-1:0]    ccol_reg, ccol_next;
    logic [ROW_W-1:0]    row_inc;

    assign row_inc = row_reg + 1'b1;

    always_comb begin
        cursor_next = cursor_reg;
        row_next    = row_reg;
        crow_next   = crow_reg;
        ccol_next   = ccol_reg;
        unique case (cmd)
            CUR_NONE: begin
            end
            CUR_CLEAR: begin
                cursor_next = '0;
                row_next    = '0;
                crow_next   = '0;
                ccol_next   = '0;
            end
            CUR_SCROLL: begin
                cursor_next = SCROLL_CURSOR;
                row_next    = LAST_ROW;
                crow_next   = LAST_ROW;
                ccol_next   = '0;
            end
            CUR_NEWLINE: begin
                cursor_next = CURSOR_W'(row_inc * COLS);
                row_next    = row_inc;
                crow_next   = row_inc;
                ccol_next   = '0;
            end
            CUR_BACK: begin
                cursor_next = cursor_reg - 1'b1;
                if (ccol_reg == '0) begin
                    ccol_next = LAST_COL;
                    crow_next = crow_reg - 1'b1;
                end else begin
                    ccol_next = ccol_reg - 1'b1;
                end
            end
            CUR_ADVANCE: begin
                if (cursor_reg < CURSOR_W'(NCELLS)) begin
                    cursor_next = cursor_reg + 1'b1;
                    if (ccol_reg == LAST_COL) begin
                        ccol_next = '0;
                        crow_next = crow_reg + 1'b1;
                    end else begin
                        ccol_next = ccol_reg + 1'b1;
                    end
                end
                row_next = crow_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            row_reg    <= '0;
            crow_reg   <= '0;
            ccol_reg   <= '0;
        end else begin
            cursor_reg <= cursor_next;
            row_reg    <= row_next;
            crow_reg   <= crow_next;
            ccol_reg   <= ccol_next;
        end
    end

    assign status.cursor = cursor_reg;
    assign status.row    = row_reg;

endmodule

FILE: hw/rtl/text_console_writer_unit.sv
// Text console writer top level: sequencer, screen memory and cursor unit.
// Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
//  channel | direction | beat contents
//  s_      | in        | op, ch, fg, bg, cell_index
//  m_      | out       | cursor_pos, read_char, read_fg, read_bg, scrolled
//  cfg_    | in        | backspace_floor, written when cfg_wr_en is high
//
// A put goes through S_PUT and a read inside the screen through S_READ, then S_DONE;
// a read past the screen or an unused op goes straight to S_DONE. A clear, and the
// scroll before a put, write one cell per cycle through the single memory write port.
// s_ready is low while an item is in work; a waiting result in the output
// register does not stop the next beat from being taken.
// Reset is synchronous on aresetn; the screen holds no valid data until written.
module text_console_writer_unit
    import tcw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CURSOR_W-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  logic [7:0]          s_ch,
    input  logic [3:0]          s_fg,
    input  logic [3:0]          s_bg,
    input  logic [10:0]         s_cell_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CURSOR_W-1:0] m_cursor_pos,
    output logic [7:0]          m_read_char,
    output logic [3:0]          m_read_fg,
    output logic [3:0]          m_read_bg,
    output logic                m_scrolled
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCROLL,
        S_FILL,
        S_CLEAR,
        S_PUT,
        S_READ,
        S_DONE
    } state_t;

    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(NCELLS - COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(NCELLS - 1);

    state_t state_reg, state_next;

    logic [CURSOR_W-1:0] floor_reg;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next, cnt_inc;
    logic [1:0]          op_reg;
    logic [7:0]          ch_reg;
    logic [3:0]          fg_reg, bg_reg;
    logic                scr_reg, scr_next;
    logic [CELL_W-1:0]   res_cell_reg, res_cell_next;

    logic                s_accept;
    logic                out_free;
    logic                m_valid_reg;
    logic [CURSOR_W-1:0] m_cursor_reg;
    logic [CELL_W-1:0]   m_cell_reg;
    logic                m_scrolled_reg;

    logic                ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [CELL_W-1:0]   ram_wr_data, ram_rd_data;

    cur_cmd_t            cur_cmd;
    cur_status_t         cur;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELLS)
    ) u_screen (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    tcw_cursor u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cur_cmd),
        .status  (cur)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_inc  = cnt_reg + 1'b1;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        scr_next      = scr_reg;
        res_cell_next = res_cell_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = cnt_reg;
        ram_wr_data   = BLANK_CELL;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = cnt_reg + ADDR_W'(COLS);
        cur_cmd       = CUR_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    scr_next      = 1'b0;
                    res_cell_next = '0;
                    cnt_next      = '0;
                    unique case (s_op)
                        OP_PUT: begin
                            if (cur.row >= ROW_W'(ROWS)) begin
                                scr_next   = 1'b1;
                                state_next = S_SCROLL;
                            end else begin
                                state_next = S_PUT;
                            end
                        end
                        OP_READ: begin
                            if (s_cell_index < 11'(NCELLS)) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = s_cell_index[ADDR_W-1:0];
                                state_next  = S_READ;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        OP_CLEAR: state_next = S_CLEAR;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_SCROLL: begin
                // The registered read of cell cnt+COLS is written to cell cnt in the next cycle.
                ram_rd_en   = (cnt_reg != COPY_END);
                ram_wr_en   = (cnt_reg != '0);
                ram_wr_addr = cnt_reg - 1'b1;
                ram_wr_data = ram_rd_data;
                if (cnt_reg == COPY_END) begin
                    state_next = S_FILL;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            S_FILL: begin
                ram_wr_en = 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    cur_cmd    = CUR_SCROLL;
                    state_next = S_PUT;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            S_CLEAR: begin
                ram_wr_en = 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    cur_cmd    = CUR_CLEAR;
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            S_PUT: begin
                state_next = S_DONE;
                priority if (ch_reg == CH_NEWLINE) begin
                    cur_cmd = CUR_NEWLINE;
                end else if (ch_reg == CH_BACKSPACE) begin
                    if (cur.cursor != floor_reg && cur.cursor != '0) begin
                        cur_cmd     = CUR_BACK;
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ADDR_W'(cur.cursor - 1'b1);
                        ram_wr_data = {fg_reg, bg_reg, CH_SPACE};
                    end
                end else begin
                    cur_cmd     = CUR_ADVANCE;
                    ram_wr_en   = (cur.cursor < CURSOR_W'(NCELLS));
                    ram_wr_addr = cur.cursor[ADDR_W-1:0];
                    ram_wr_data = {fg_reg, bg_reg, ch_reg};
                end
            end
            S_READ: begin
                res_cell_next = ram_rd_data;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            floor_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            scr_reg      <= scr_next;
            res_cell_reg <= res_cell_next;
            if (cfg_wr_en) begin
                floor_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                op_reg <= s_op;
                ch_reg <= s_ch;
                fg_reg <= s_fg;
                bg_reg <= s_bg;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg    <= 1'b1;
                m_cursor_reg   <= cur.cursor;
                m_cell_reg     <= res_cell_reg;
                m_scrolled_reg <= scr_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = m_cursor_reg;
    assign m_read_char  = m_cell_reg[7:0];
    assign m_read_fg    = m_cell_reg[15:12];
    assign m_read_bg    = m_cell_reg[11:8];
    assign m_scrolled   = m_scrolled_reg;

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (ram_wr_addr <= LAST_CELL))
        else $error("screen write outside the cell array");

    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur.cursor <= CURSOR_W'(NCELLS)) && (cur.row <= ROW_W'(ROWS)))
        else $error("cursor or cursor row beyond the screen");

    a_scroll_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_op == OP_PUT && cur.row >= ROW_W'(ROWS)) |=> (state_reg == S_SCROLL))
        else $error("put at the bottom row did not start a scroll");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> (m_valid && state_reg == S_IDLE))
        else $error("finished item did not reach the output register");

    a_read_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (op_reg == OP_READ))
        else $error("read wait entered for an item that is not a read");

endmodule

FILE: sim/tb_text_console_writer_unit.sv
// Testbench for text_console_writer_unit. It holds a scoreboard class that
// mirrors the screen, the cursor and the backspace floor. Depends on tcw_pkg and text_console_writer_unit.
`timescale 1ns / 100ps

module tb_text_console_writer_unit
    import tcw_pkg::*;
();

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int ADDR_TOP    = 2047;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_pos;
        logic [7:0]          rd_char;
        logic [3:0]          rd_fg;
        logic [3:0]          rd_bg;
        logic                scrolled;
    } console_result_t;

    class console_scoreboard;
        logic [CELL_W-1:0]   screen [NCELLS];
        bit                  known [NCELLS];
        int unsigned         cursor;
        int unsigned         row;
        logic [CURSOR_W-1:0] floor_pos;
        console_result_t     awaited [$];
        int                  errors;
        int                  beats_in;
        int                  results_seen;
        int                  scrolls;
        int                  reads;
        int                  clears;

        function new();
            foreach (screen[i]) begin
                screen[i] = '0;
                known[i]  = 1'b0;
            end
            cursor = 0;
            row = 0;
            floor_pos = '0;
        endfunction

        // Works out the result of one accepted input beat and updates the mirror.
        function void note_beat(logic [1:0] op, logic [7:0] ch, logic [3:0] fg,
                                logic [3:0] bg, logic [10:0] idx);
            console_result_t r;
            r = '0;
            beats_in++;
            case (op)
                OP_PUT: begin
                    if (row >= ROWS) begin
                        for (int i = 0; i + COLS < NCELLS; i++) begin
                            screen[i] = screen[i + COLS];
                            known[i]  = known[i + COLS];
                        end
                        for (int i = NCELLS - COLS; i < NCELLS; i++) begin
                            screen[i] = BLANK_CELL;
                            known[i]  = 1'b1;
                        end
                        row = ROWS - 1;
                        cursor = row * COLS;
                        r.scrolled = 1'b1;
                        scrolls++;
                    end
                    if (ch == CH_NEWLINE) begin
                        row++;
                        cursor = row * COLS;
                    end else if (ch == CH_BACKSPACE) begin
                        if (cursor != floor_pos && cursor != 0) begin
                            cursor--;
                            screen[cursor] = {fg, bg, CH_SPACE};
                            known[cursor]  = 1'b1;
                        end
                    end else begin
                        if (cursor < NCELLS) begin
                            screen[cursor] = {fg, bg, ch};
                            known[cursor]  = 1'b1;
                            cursor++;
                        end
                        row = cursor / COLS;
                    end
                end
                OP_READ: begin
                    if (idx < NCELLS) begin
                        r.rd_char = screen[idx][7:0];
                        r.rd_fg   = screen[idx][15:12];
                        r.rd_bg   = screen[idx][11:8];
                    end
                    reads++;
                end
                OP_CLEAR: begin
                    foreach (screen[i]) begin
                        screen[i] = BLANK_CELL;
                        known[i]  = 1'b1;
                    end
                    cursor = 0;
                    row = 0;
                    clears++;
                end
                default: ;
            endcase
            r.cursor_pos = cursor[CURSOR_W-1:0];
            awaited.push_back(r);
        endfunction

        function void match_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            results_seen++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with nothing expected, cursor_pos %0d",
                         $time, got.cursor_pos);
                return;
            end
            want = awaited.pop_front();
            match_field("cursor_pos", want.cursor_pos, got.cursor_pos);
            match_field("read_char", want.rd_char, got.rd_char);
            match_field("read_fg", want.rd_fg, got.rd_fg);
            match_field("read_bg", want.rd_bg, got.rd_bg);
            match_field("scrolled", want.scrolled, got.scrolled);
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CURSOR_W-1:0] cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_op = OP_PUT;
    logic [7:0]          s_ch = '0;
    logic [3:0]          s_fg = '0;
    logic [3:0]          s_bg = '0;
    logic [10:0]         s_cell_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CURSOR_W-1:0] m_cursor_pos;
    logic [7:0]          m_read_char;
    logic [3:0]          m_read_fg;
    logic [3:0]          m_read_bg;
    logic                m_scrolled;

    console_scoreboard sb;
    bit calm = 1'b0;
    int quiet_cycles = 0;

    text_console_writer_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_ch         (s_ch),
        .s_fg         (s_fg),
        .s_bg         (s_bg),
        .s_cell_index (s_cell_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_pos (m_cursor_pos),
        .m_read_char  (m_read_char),
        .m_read_fg    (m_read_fg),
        .m_read_bg    (m_read_bg),
        .m_scrolled   (m_scrolled)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 29);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_beat(s_op, s_ch, s_fg, s_bg, s_cell_index);
            if (m_valid && m_ready)
                sb.check_result({m_cursor_pos, m_read_char, m_read_fg, m_read_bg,
                                 m_scrolled});
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("text_console_writer_unit verification failed");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(logic [1:0] op, logic [7:0] ch, logic [3:0] fg,
                             logic [3:0] bg, logic [10:0] idx);
        while (!calm && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_ch         <= ch;
        s_fg         <= fg;
        s_bg         <= bg;
        s_cell_index <= idx;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain(int extra);
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_floor(logic [CURSOR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.floor_pos = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly typing with newlines and runs of backspaces; reads only touch cells
    // that hold data, or addresses past the screen.
    task automatic random_phase(int count, int nl_pct);
        int          done_items;
        int          bs_left;
        int          pick;
        int unsigned lo;
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [10:0] idx;
        done_items = 0;
        bs_left = 0;
        while (done_items < count) begin
            op   = OP_PUT;
            ch   = 8'($urandom_range(0, 255));
            idx  = 11'($urandom_range(0, ADDR_TOP));
            pick = $urandom_range(0, 99);
            if (bs_left > 0) begin
                ch = CH_BACKSPACE;
                bs_left--;
            end else if (pick < 1) begin
                op = OP_CLEAR;
            end else if (pick < 3) begin
                op = OP_UNUSED;
            end else if (pick < 15) begin
                op = OP_READ;
                if (pick < 12 && sb.cursor > 0) begin
                    lo  = (sb.cursor > 160) ? sb.cursor - 160 : 0;
                    idx = 11'($urandom_range(lo, sb.cursor - 1));
                end
                if (idx < NCELLS && !sb.known[idx])
                    idx = 11'($urandom_range(NCELLS, ADDR_TOP));
            end else if (pick < 15 + nl_pct) begin
                ch = CH_NEWLINE;
            end else if (pick < 27 + nl_pct) begin
                ch = CH_BACKSPACE;
                bs_left = $urandom_range(0, 7);
            end
            send_beat(op, ch, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), idx);
            if (op != OP_UNUSED)
                done_items++;
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening with the floor just past a short prompt.
        write_floor(11'd5);
        send_beat(OP_PUT, CH_BACKSPACE, 4'h3, 4'h4, 11'd0);   // backspace at home
        send_beat(OP_PUT, 8'h00, 4'h0, 4'h0, 11'd0);
        send_beat(OP_PUT, 8'hFF, 4'hF, 4'hF, 11'd0);
        send_beat(OP_READ, 8'h00, 4'h0, 4'h0, 11'd0);
        send_beat(OP_READ, 8'hFF, 4'hF, 4'hF, 11'd1);
        send_beat(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2047);
        send_beat(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2000);
        send_beat(OP_UNUSED, 8'hFF, 4'hF, 4'hF, 11'd2047);
        send_beat(OP_PUT, 8'h61, 4'hA, 4'h5, 11'd0);
        send_beat(OP_PUT, 8'h62, 4'h5, 4'hA, 11'd0);
        send_beat(OP_PUT, 8'h63, 4'h1, 4'h2, 11'd0);
        send_beat(OP_PUT, CH_BACKSPACE, 4'h7, 4'h7, 11'd0);   // blocked at the floor
        send_beat(OP_PUT, CH_NEWLINE, 4'h0, 4'h0, 11'd0);
        send_beat(OP_PUT, CH_BACKSPACE, 4'hC, 4'h3, 11'd0);   // back into the row above
        send_beat(OP_READ, 8'h00, 4'h0, 4'h0, 11'd79);
        send_beat(OP_PUT, 8'h78, 4'h9, 4'h6, 11'd0);
        send_beat(OP_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0);
        send_beat(OP_READ, 8'h00, 4'h0, 4'h0, 11'd1999);
        send_beat(OP_READ, 8'h00, 4'h0, 4'h0, 11'd0);
        send_beat(OP_PUT, 8'h80, 4'h6, 4'h9, 11'd1024);
        send_beat(OP_PUT, CH_BACKSPACE, 4'hF, 4'h0, 11'd0);
        drain(4);

        write_floor(11'd0);
        random_phase(250, 12);
        drain(4);

        write_floor(11'd2000);
        random_phase(200, 2);
        drain(4);

        // The floor sits at the current cursor, like the end of a shell prompt.
        write_floor(11'(sb.cursor));
        calm = 1'b1;
        random_phase(120, 12);
        calm = 1'b0;
        random_phase(130, 12);
        drain(4);

        write_floor(11'(sb.cursor));
        random_phase(200, 6);
        drain(20);

        $display("Sent %0d beats and checked %0d results: %0d scrolls, %0d reads, %0d clears,",
                 sb.beats_in, sb.results_seen, sb.scrolls, sb.reads, sb.clears);
        $display("with backspace floors at 0, 5, 2000 and at prompt positions.");
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("text_console_writer_unit verification clean");
        end else begin
            $display("text_console_writer_unit verification failed");
        end
        $finish;
    end

endmodule
